// ----- rtl/hsv_pkg.sv -----
package hsv_pkg;

   localparam int FRAC_W = 16;
   localparam int FIX_W  = FRAC_W + 1;
   localparam int HUE6_W = FRAC_W + 3;

   localparam logic [FIX_W-1:0] FX_ONE = FIX_W'(1) << FRAC_W;

   // Colour sector of the hue circle, from red towards magenta.
   typedef enum logic [2:0] {
      SEC_RY = 3'd0,
      SEC_YG = 3'd1,
      SEC_GC = 3'd2,
      SEC_CB = 3'd3,
      SEC_BM = 3'd4,
      SEC_MR = 3'd5
   } sector_type;

   typedef struct packed {
      sector_type        sector;
      logic [FRAC_W-1:0] frac;
      logic [FIX_W-1:0]  sat;
      logic [FIX_W-1:0]  val;
      logic [FIX_W-1:0]  alpha;
   } stage1_type;

   typedef struct packed {
      sector_type       sector;
      logic [FIX_W-1:0] sf;
      logic [FIX_W-1:0] sfc;
      logic [FIX_W-1:0] p;
      logic [FIX_W-1:0] val;
      logic [FIX_W-1:0] alpha;
   } stage2_type;

   typedef struct packed {
      logic [FIX_W-1:0] red;
      logic [FIX_W-1:0] green;
      logic [FIX_W-1:0] blue;
      logic [FIX_W-1:0] alpha;
   } pixel_type;

   // Values above one are pinned to one.
   function automatic logic [FIX_W-1:0] clamp_one(input logic [FIX_W-1:0] x);
      return (x > FX_ONE) ? FX_ONE : x;
   endfunction

   // Fractional product, truncated. Both operands are at most one, so the
   // product fits in 2*FRAC_W+1 bits and the result is at most one.
   function automatic logic [FIX_W-1:0] mul_frac(input logic [FIX_W-1:0] a,
                                                  input logic [FIX_W-1:0] b);
      logic [2*FIX_W-1:0] prod;
      prod = (2*FIX_W)'(a) * (2*FIX_W)'(b);
      return prod[2*FRAC_W:FRAC_W];
   endfunction

endpackage

// ----- rtl/hsv_sector.sv -----
module hsv_sector (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  logic                       in_valid,
   input  logic [hsv_pkg::FRAC_W-1:0] hue,
   input  logic [hsv_pkg::FIX_W-1:0]  saturation,
   input  logic [hsv_pkg::FIX_W-1:0]  brightness,
   input  logic [hsv_pkg::FIX_W-1:0]  alpha_in,
   output logic                       valid_ff,
   output hsv_pkg::stage1_type        stage_ff
);

   logic [hsv_pkg::HUE6_W-1:0] hue6;
   hsv_pkg::stage1_type        stage_in;

   // Hue times six as a sum of two shifts.
   assign hue6 = hsv_pkg::HUE6_W'({hue, 2'b00}) + hsv_pkg::HUE6_W'({hue, 1'b0});

   always_comb begin
      stage_in.sector = hsv_pkg::sector_type'(hue6[hsv_pkg::HUE6_W-1:hsv_pkg::FRAC_W]);
      stage_in.frac   = hue6[hsv_pkg::FRAC_W-1:0];
      stage_in.sat    = hsv_pkg::clamp_one(saturation);
      stage_in.val    = hsv_pkg::clamp_one(brightness);
      stage_in.alpha  = alpha_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

endmodule

// ----- rtl/hsv_levels.sv -----
module hsv_levels (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                in_valid,
   input  hsv_pkg::stage1_type stage_in,
   output logic                valid_ff,
   output hsv_pkg::stage2_type stage_ff
);

   logic [hsv_pkg::FIX_W-1:0] frac_ext;
   hsv_pkg::stage2_type       next_in;

   assign frac_ext = {1'b0, stage_in.frac};

   always_comb begin
      next_in.sector = stage_in.sector;
      next_in.sf     = hsv_pkg::mul_frac(stage_in.sat, frac_ext);
      next_in.sfc    = hsv_pkg::mul_frac(stage_in.sat, hsv_pkg::FX_ONE - frac_ext);
      next_in.p      = hsv_pkg::mul_frac(stage_in.val, hsv_pkg::FX_ONE - stage_in.sat);
      next_in.val    = stage_in.val;
      next_in.alpha  = stage_in.alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= next_in;
      end
   end

endmodule

// ----- rtl/hsv_mix.sv -----
module hsv_mix (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                in_valid,
   input  hsv_pkg::stage2_type stage_in,
   output logic                valid_ff,
   output hsv_pkg::pixel_type  pixel_ff
);

   logic [hsv_pkg::FIX_W-1:0] q;
   logic [hsv_pkg::FIX_W-1:0] t;
   hsv_pkg::pixel_type        pixel_in;

   assign q = hsv_pkg::mul_frac(stage_in.val, hsv_pkg::FX_ONE - stage_in.sf);
   assign t = hsv_pkg::mul_frac(stage_in.val, hsv_pkg::FX_ONE - stage_in.sfc);

   // Zero saturation needs no special path: P, Q and T all come out as V.
   always_comb begin
      pixel_in.alpha = stage_in.alpha;
      unique case (stage_in.sector)
         hsv_pkg::SEC_RY: begin
            pixel_in.red   = stage_in.val;
            pixel_in.green = t;
            pixel_in.blue  = stage_in.p;
         end
         hsv_pkg::SEC_YG: begin
            pixel_in.red   = q;
            pixel_in.green = stage_in.val;
            pixel_in.blue  = stage_in.p;
         end
         hsv_pkg::SEC_GC: begin
            pixel_in.red   = stage_in.p;
            pixel_in.green = stage_in.val;
            pixel_in.blue  = t;
         end
         hsv_pkg::SEC_CB: begin
            pixel_in.red   = stage_in.p;
            pixel_in.green = q;
            pixel_in.blue  = stage_in.val;
         end
         hsv_pkg::SEC_BM: begin
            pixel_in.red   = t;
            pixel_in.green = stage_in.p;
            pixel_in.blue  = stage_in.val;
         end
         default: begin
            pixel_in.red   = stage_in.val;
            pixel_in.green = stage_in.p;
            pixel_in.blue  = q;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pixel_ff <= pixel_in;
      end
   end

endmodule

// ----- rtl/hsv_to_rgb_converter.sv -----
// HSV to RGB pixel converter. A transaction is accepted on every clock in
// which req_valid is high and req_stall is low, and one pixel per clock is
// sustained while rsp_stall is low. Each transaction passes three register
// stages in order: the sector and clamping stage, the stage holding the
// first layer of multipliers (S*f, S*(1-f) and V*(1-S)), and the stage
// holding the second layer (V*(1-S*f), V*(1-S*(1-f))) together with the
// sector mapping, which is also the output register. A stall on rsp_stall
// holds the whole pipeline only once it is full; empty stages keep filling.
// Saturation and brightness above one are treated as one, alpha passes
// through unchanged and all products truncate.
module hsv_to_rgb_converter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [hsv_pkg::FRAC_W-1:0] req_hue,
   input  logic [hsv_pkg::FIX_W-1:0]  req_saturation,
   input  logic [hsv_pkg::FIX_W-1:0]  req_brightness,
   input  logic [hsv_pkg::FIX_W-1:0]  req_alpha_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [hsv_pkg::FIX_W-1:0]  rsp_red,
   output logic [hsv_pkg::FIX_W-1:0]  rsp_green,
   output logic [hsv_pkg::FIX_W-1:0]  rsp_blue,
   output logic [hsv_pkg::FIX_W-1:0]  rsp_alpha_out
);

   logic                valid1;
   logic                valid2;
   logic                enable1;
   logic                enable2;
   logic                enable3;
   hsv_pkg::stage1_type stage1;
   hsv_pkg::stage2_type stage2;
   hsv_pkg::pixel_type  pixel;

   // A stage advances when the one after it is empty or advancing itself.
   assign enable3   = !rsp_valid || !rsp_stall;
   assign enable2   = !valid2 || enable3;
   assign enable1   = !valid1 || enable2;
   assign req_stall = !enable1;

   hsv_sector u_sector (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable1),
      .in_valid   (req_valid),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .alpha_in   (req_alpha_in),
      .valid_ff   (valid1),
      .stage_ff   (stage1)
   );

   hsv_levels u_levels (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable2),
      .in_valid (valid1),
      .stage_in (stage1),
      .valid_ff (valid2),
      .stage_ff (stage2)
   );

   hsv_mix u_mix (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable3),
      .in_valid (valid2),
      .stage_in (stage2),
      .valid_ff (rsp_valid),
      .pixel_ff (pixel)
   );

   assign rsp_red       = pixel.red;
   assign rsp_green     = pixel.green;
   assign rsp_blue      = pixel.blue;
   assign rsp_alpha_out = pixel.alpha;

   // The input is only held off when every stage holds a transaction.
   a_stall_only_when_full: assert property (
      @(posedge clock) disable iff (reset)
      req_stall |-> (valid1 && valid2 && rsp_valid && rsp_stall)
   ) else $error("input stalled while the pipeline has room");

   // A transaction held in the middle stage is not dropped by a stall.
   a_stage2_kept: assert property (
      @(posedge clock) disable iff (reset)
      (valid2 && !enable3) |=> (valid2 && $stable(stage2))
   ) else $error("middle stage lost or changed a held transaction");

   // Colour levels never exceed one.
   a_colour_range: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_red <= hsv_pkg::FX_ONE && rsp_green <= hsv_pkg::FX_ONE
                     && rsp_blue <= hsv_pkg::FX_ONE)
   ) else $error("colour level above one");

   // Clamped operands in the first stage stay within one.
   a_operand_range: assert property (
      @(posedge clock) disable iff (reset)
      valid1 |-> (stage1.sat <= hsv_pkg::FX_ONE && stage1.val <= hsv_pkg::FX_ONE)
   ) else $error("saturation or brightness not clamped");

endmodule
